FILE: rtl/snp_pkg.sv
// Package for the raw Snappy decompressor.
// Holds phase codes, result status codes and the controller/datapath structs.
package snp_pkg;

  localparam int unsigned SnpHistDepth = 65536;

  localparam logic [2:0] PH_PREAMBLE = 3'd0;
  localparam logic [2:0] PH_TAG      = 3'd1;
  localparam logic [2:0] PH_LITLEN   = 3'd2;
  localparam logic [2:0] PH_LITDATA  = 3'd3;
  localparam logic [2:0] PH_COPYOFF  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNC     = 2'd1;
  localparam logic [1:0] ST_BAD_OFF   = 2'd2;
  localparam logic [1:0] ST_LONG_PRE  = 2'd3;

  localparam logic [1:0] TAG_LITERAL = 2'd0;
  localparam logic [1:0] TAG_COPY1   = 2'd1;
  localparam logic [1:0] TAG_COPY2   = 2'd2;
  localparam logic [1:0] TAG_COPY4   = 2'd3;

  typedef struct packed {
    logic accept;
    logic rd;
    logic wr;
    logic put_extra;
  } snp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic copy_start;
    logic need_extra;
    logic copy_done;
  } snp_sts_t;

endpackage

FILE: rtl/snp_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module snp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/snp_ctrl.sv
// Sequencer for the Snappy decompressor: input accept, copy read/write steps,
// trailing error result. Depends on snp_pkg.
module snp_ctrl import snp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  snp_sts_t sts,
  output snp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = sts.out_free;
        cmd.accept = in_tvalid & sts.out_free;
        if (cmd.accept && sts.copy_start) begin
          state_nxt = S_RD;
        end else if (cmd.accept && sts.need_extra) begin
          state_nxt = S_END;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (sts.out_free) begin
          cmd.wr    = 1'b1;
          state_nxt = sts.copy_done ? S_IDLE : S_RD;
        end
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.put_extra = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/snp_dp.sv
// Datapath for the Snappy decompressor: tag decode, counters, history RAM,
// output register. Depends on snp_pkg and snp_ram.
module snp_dp import snp_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = SnpHistDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  snp_cmd_t   cmd,
  output snp_sts_t   sts,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_byte,
  output logic       out_present,
  output logic       out_end,
  output logic [1:0] out_status
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned PW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [PW-1:0] DepthP = PW'(HISTORY_DEPTH);

  logic [2:0]    phase_r, phase_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [6:0]    shift_r, shift_nxt;
  logic [32:0]   run_r, run_nxt;
  logic [31:0]   off_r, off_nxt;
  logic [2:0]    extra_r, extra_nxt;
  logic          swallow_r, swallow_nxt;
  logic          last_r, last_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [1:0]    pend_r, pend_nxt;

  logic          ov_r, ov_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic          op_r, op_nxt;
  logic          oe_r, oe_nxt;
  logic [1:0]    os_r, os_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic [1:0]    err;
  logic          lit_emit, copy_start, new_stream;
  logic [5:0]    len;
  logic [32:0]   run_or;
  logic [31:0]   off_or;
  logic [2:0]    extra_dec;
  logic [PW-1:0] wpx, offx;
  logic [PW-1:0] src_calc;
  logic [AW-1:0] wp_inc, src_inc;
  logic [PW-1:0] prod_inc;
  logic [6:0]    shift_add;

  assign sts.out_free   = ~ov_r | out_tready;
  assign sts.copy_done  = (run_r == 33'd1);
  assign sts.copy_start = copy_start;
  assign sts.need_extra = lit_emit & (err != ST_OK);

  assign len       = in_byte[7:2];
  assign run_or    = run_r | (33'(in_byte) << shift_r[4:0]);
  assign off_or    = off_r | (32'(in_byte) << shift_r[4:0]);
  assign extra_dec = extra_r - 3'd1;
  assign wpx       = PW'(wp_r);
  assign offx      = off_or[PW-1:0];
  assign src_calc  = (wpx >= offx) ? (wpx - offx) : (wpx + DepthP - offx);
  assign wp_inc    = (PW'(wp_r) + PW'(1) >= DepthP) ? '0 : wp_r + AW'(1);
  assign src_inc   = (PW'(src_r) + PW'(1) >= DepthP) ? '0 : src_r + AW'(1);
  assign prod_inc  = (prod_r < DepthP) ? prod_r + PW'(1) : prod_r;
  assign shift_add = shift_r + 7'd7;

  always_comb begin
    phase_nxt   = phase_r;
    wp_nxt      = wp_r;
    prod_nxt    = prod_r;
    shift_nxt   = shift_r;
    run_nxt     = run_r;
    off_nxt     = off_r;
    extra_nxt   = extra_r;
    swallow_nxt = swallow_r;
    last_nxt    = last_r;
    src_nxt     = src_r;
    pend_nxt    = pend_r;
    ov_nxt      = ov_r & ~out_tready;
    ob_nxt      = ob_r;
    op_nxt      = op_r;
    oe_nxt      = oe_r;
    os_nxt      = os_r;
    ram_we      = 1'b0;
    ram_waddr   = wp_r;
    ram_wdata   = in_byte;
    err         = ST_OK;
    lit_emit    = 1'b0;
    copy_start  = 1'b0;
    new_stream  = 1'b0;

    if (!swallow_r) begin
      case (phase_r)
        PH_PREAMBLE: begin
          if (in_byte[7]) begin
            shift_nxt = shift_add;
            if (shift_add >= 7'd64) begin
              err = ST_LONG_PRE;
            end else if (in_last) begin
              err = ST_TRUNC;
            end
          end else begin
            phase_nxt = PH_TAG;
          end
        end
        PH_TAG: begin
          shift_nxt = '0;
          off_nxt   = '0;
          if (in_byte[1:0] == TAG_LITERAL) begin
            if (len < 6'd60) begin
              run_nxt   = 33'(len) + 33'd1;
              phase_nxt = PH_LITDATA;
            end else begin
              extra_nxt = 3'(len - 6'd59);
              run_nxt   = '0;
              phase_nxt = PH_LITLEN;
            end
          end else begin
            if (in_byte[1:0] == TAG_COPY1) begin
              run_nxt   = 33'(in_byte[4:2]) + 33'd4;
              off_nxt   = {21'd0, in_byte[7:5], 8'd0};
              extra_nxt = 3'd1;
            end else begin
              run_nxt   = 33'(len) + 33'd1;
              extra_nxt = (in_byte[1:0] == TAG_COPY2) ? 3'd2 : 3'd4;
            end
            phase_nxt = PH_COPYOFF;
          end
          if (in_last) begin
            err = ST_TRUNC;
          end
        end
        PH_LITLEN: begin
          run_nxt   = run_or;
          shift_nxt = shift_r + 7'd8;
          extra_nxt = extra_dec;
          if (extra_dec == 3'd0) begin
            run_nxt   = run_or + 33'd1;
            phase_nxt = PH_LITDATA;
          end
          if (in_last) begin
            err = ST_TRUNC;
          end
        end
        PH_LITDATA: begin
          lit_emit = 1'b1;
          if (run_r != '0) begin
            run_nxt = run_r - 33'd1;
          end
          if (run_r <= 33'd1) begin
            phase_nxt = PH_TAG;
          end else if (in_last) begin
            err = ST_TRUNC;
          end
        end
        PH_COPYOFF: begin
          off_nxt   = off_or;
          shift_nxt = shift_r + 7'd8;
          extra_nxt = extra_dec;
          if (extra_dec == 3'd0) begin
            if (off_or == '0 || off_or > 32'(prod_r)) begin
              err = ST_BAD_OFF;
            end else begin
              copy_start = 1'b1;
              src_nxt    = src_calc[AW-1:0];
            end
          end else if (in_last) begin
            err = ST_TRUNC;
          end
        end
        default: phase_nxt = PH_TAG;
      endcase
    end

    if (cmd.accept) begin
      if (swallow_r) begin
        new_stream = in_last;
      end else begin
        if (lit_emit) begin
          ram_we   = 1'b1;
          wp_nxt   = wp_inc;
          prod_nxt = prod_inc;
          ov_nxt   = 1'b1;
          ob_nxt   = in_byte;
          op_nxt   = 1'b1;
          oe_nxt   = in_last & (err == ST_OK);
          os_nxt   = ST_OK;
          pend_nxt = err;
        end else if (err != ST_OK || (in_last && !copy_start)) begin
          ov_nxt = 1'b1;
          ob_nxt = '0;
          op_nxt = 1'b0;
          oe_nxt = 1'b1;
          os_nxt = err;
        end
        if (err != ST_OK) begin
          if (in_last) begin
            new_stream = 1'b1;
          end else begin
            swallow_nxt = 1'b1;
          end
        end else if (in_last) begin
          if (copy_start) begin
            last_nxt = 1'b1;
          end else begin
            new_stream = 1'b1;
          end
        end
      end
    end else begin
      phase_nxt = phase_r;
      shift_nxt = shift_r;
      run_nxt   = run_r;
      off_nxt   = off_r;
      extra_nxt = extra_r;
      src_nxt   = src_r;
    end

    if (cmd.wr) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
      wp_nxt    = wp_inc;
      prod_nxt  = prod_inc;
      src_nxt   = src_inc;
      run_nxt   = run_r - 33'd1;
      ov_nxt    = 1'b1;
      ob_nxt    = ram_rdata;
      op_nxt    = 1'b1;
      oe_nxt    = last_r & sts.copy_done;
      os_nxt    = ST_OK;
      if (sts.copy_done) begin
        phase_nxt  = PH_TAG;
        new_stream = last_r;
      end
    end

    if (cmd.put_extra) begin
      ov_nxt = 1'b1;
      ob_nxt = '0;
      op_nxt = 1'b0;
      oe_nxt = 1'b1;
      os_nxt = pend_r;
    end

    if (new_stream) begin
      phase_nxt   = PH_PREAMBLE;
      wp_nxt      = '0;
      prod_nxt    = '0;
      shift_nxt   = '0;
      run_nxt     = '0;
      off_nxt     = '0;
      extra_nxt   = '0;
      swallow_nxt = 1'b0;
      last_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PREAMBLE;
      wp_r      <= '0;
      prod_r    <= '0;
      shift_r   <= '0;
      run_r     <= '0;
      off_r     <= '0;
      extra_r   <= '0;
      swallow_r <= 1'b0;
      last_r    <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      wp_r      <= wp_nxt;
      prod_r    <= prod_nxt;
      shift_r   <= shift_nxt;
      run_r     <= run_nxt;
      off_r     <= off_nxt;
      extra_r   <= extra_nxt;
      swallow_r <= swallow_nxt;
      last_r    <= last_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    pend_r <= pend_nxt;
    ob_r   <= ob_nxt;
    op_r   <= op_nxt;
    oe_r   <= oe_nxt;
    os_r   <= os_nxt;
  end

  snp_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd),
    .raddr(src_r),
    .rdata(ram_rdata)
  );

  assign out_tvalid  = ov_r;
  assign out_byte    = ob_r;
  assign out_present = op_r;
  assign out_end     = oe_r;
  assign out_status  = os_r;

endmodule

FILE: rtl/snappy_raw_decompressor.sv
// Raw Snappy decompressor, top level.
// Input: one compressed byte per transaction on in_* (tdata = byte,
//   tlast = final byte of the stream). Output: one result per transaction
//   on out_* (tdata = decompressed byte, tuser = byte_present and status,
//   tlast = last result of the stream).
// Each stream opens with a length varint, which is skipped; then literal
//   and copy tags follow. Literal bytes go out as they arrive; copy bytes
//   are read back from a HISTORY_DEPTH-byte history RAM.
// Copies: each copied byte takes a RAM read state, then a write-back and
//   output state, as the single history RAM has a registered read; no new
//   input is taken during a copy. A literal byte that also ends in an error
//   is followed by a separate error result.
// Errors (truncated input, bad offset, overlong preamble) give one result
//   with byte_present 0, status nonzero and tlast set; later input is
//   dropped up to and including the next tlast byte.
// Reset clears all control state and starts a new stream; the history RAM
//   is not cleared. When the receiver stalls, the output register holds and
//   no new input is taken until it frees.
module snappy_raw_decompressor import snp_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = SnpHistDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [2:0]  out_tuser,  // [0] byte_present, [2:1] status
  output logic        out_tlast
);

  snp_cmd_t   cmd;
  snp_sts_t   sts;
  logic       present;
  logic [1:0] status;

  snp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  snp_dp #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_present(present),
    .out_end    (out_tlast),
    .out_status (status)
  );

  assign out_tuser = {status, present};

endmodule

FILE: tb/snappy_raw_decompressor_tb.sv
// Self-checking testbench for snappy_raw_decompressor: random and directed Snappy streams.
// A scoreboard class predicts the output transactions; depends on rtl/snp_pkg.sv and the top.
`timescale 1ns / 100ps

module snappy_raw_decompressor_tb;
  import snp_pkg::*;

  typedef struct {
    bit [7:0] data;
    bit       present;
    bit       last;
    bit [1:0] status;
  } dec_result_t;

  typedef struct {
    bit [7:0] data;
    bit       last;
  } comp_byte_t;

  class snappy_scoreboard;
    bit [7:0]          hist [0:SnpHistDepth-1];
    logic [2:0]        phase;
    int unsigned       wr_ptr;
    int unsigned       produced;
    int unsigned       shift;
    longint unsigned   run_len;
    int unsigned       offset;
    int unsigned       extra_left;
    bit                swallow;
    dec_result_t       expected_q[$];
    dec_result_t       step_q[$];
    int                errors;

    function void restart();
      phase = PH_PREAMBLE;
      wr_ptr = 0;
      produced = 0;
      shift = 0;
      run_len = 0;
      offset = 0;
      extra_left = 0;
      swallow = 0;
    endfunction

    function void push(bit [7:0] d, bit p, bit l, bit [1:0] s);
      dec_result_t r;
      r.data = d;
      r.present = p;
      r.last = l;
      r.status = s;
      step_q = {step_q, r};
    endfunction

    function void emit(bit [7:0] v);
      hist[wr_ptr] = v;
      wr_ptr = (wr_ptr + 1 >= SnpHistDepth) ? 0 : wr_ptr + 1;
      if (produced < SnpHistDepth) produced++;
      push(v, 1'b1, 1'b0, ST_OK);
    endfunction

    function void note_input(bit [7:0] b, bit l);
      logic [1:0]  err;
      logic [1:0]  kind;
      int unsigned len;
      int unsigned src;
      err = ST_OK;
      step_q.delete();
      if (swallow) begin
        if (l) restart();
        return;
      end
      case (phase)
        PH_PREAMBLE: begin
          if (b[7]) begin
            shift += 7;
            if (shift >= 64) err = ST_LONG_PRE;
            else if (l) err = ST_TRUNC;
          end else begin
            phase = PH_TAG;
          end
        end
        PH_TAG: begin
          kind = b[1:0];
          len = b >> 2;
          shift = 0;
          offset = 0;
          if (kind == TAG_LITERAL) begin
            if (len < 60) begin
              run_len = len + 1;
              phase = PH_LITDATA;
            end else begin
              extra_left = len - 59;
              run_len = 0;
              phase = PH_LITLEN;
            end
          end else begin
            if (kind == TAG_COPY1) begin
              run_len = (len & 7) + 4;
              offset = (b >> 5) << 8;
              extra_left = 1;
            end else begin
              run_len = len + 1;
              extra_left = (kind == TAG_COPY2) ? 2 : 4;
            end
            phase = PH_COPYOFF;
          end
          if (l) err = ST_TRUNC;
        end
        PH_LITLEN: begin
          run_len |= longint'(b) << (shift & 31);
          shift += 8;
          extra_left = (extra_left - 1) & 7;
          if (extra_left == 0) begin
            run_len += 1;
            phase = PH_LITDATA;
          end
          if (l) err = ST_TRUNC;
        end
        PH_LITDATA: begin
          emit(b);
          if (run_len > 0) run_len--;
          if (run_len == 0) phase = PH_TAG;
          else if (l) err = ST_TRUNC;
        end
        PH_COPYOFF: begin
          offset |= int'(b) << (shift & 31);
          shift += 8;
          extra_left = (extra_left - 1) & 7;
          if (extra_left == 0) begin
            if (offset == 0 || offset > produced) begin
              err = ST_BAD_OFF;
            end else begin
              src = (wr_ptr >= offset) ? wr_ptr - offset : wr_ptr + SnpHistDepth - offset;
              for (longint unsigned i = 0; i < run_len && step_q.size() < 64; i++) begin
                emit(hist[src]);
                src = (src + 1 >= SnpHistDepth) ? 0 : src + 1;
              end
              run_len = 0;
              phase = PH_TAG;
            end
          end else if (l) begin
            err = ST_TRUNC;
          end
        end
        default: phase = PH_TAG;
      endcase
      if (err != ST_OK) begin
        push(8'h00, 1'b0, 1'b1, err);
        if (l) restart();
        else swallow = 1;
      end else if (l) begin
        if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
        else push(8'h00, 1'b0, 1'b1, ST_OK);
        restart();
      end
      expected_q = {expected_q, step_q};
    endfunction

    function void check_result(logic [7:0] d, logic [2:0] u, logic l);
      dec_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result data=%h user=%b last=%b", $time, d, u, l);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (d !== e.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, e.data, d);
        errors++;
      end
      if (u[0] !== e.present) begin
        $display("%0t: byte_present expected %b actual %b", $time, e.present, u[0]);
        errors++;
      end
      if (u[2:1] !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, u[2:1]);
        errors++;
      end
      if (l !== e.last) begin
        $display("%0t: stream_end expected %b actual %b", $time, e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  snappy_raw_decompressor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  snappy_scoreboard sb = new();
  comp_byte_t       comp_q[$];
  int               idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add(bit [7:0] b, bit l = 1'b0);
    comp_byte_t c;
    c.data = b;
    c.last = l;
    comp_q = {comp_q, c};
  endfunction

  function automatic int draw_gap(int count);
    // every 40 transactions, pick between a busy stretch and a stretch with idling
    static bit gaps_on [2];
    int side;
    side = int'(count < 0);
    if ((count % 40) == 0) gaps_on[side] = $urandom_range(0, 2) != 0;
    return gaps_on[side] ? int'($urandom_range(0, 13)) : 0;
  endfunction

  function automatic void directed_streams();
    // all tag forms, overlapping copies, long copy
    add(8'h05); add(8'h00); add(8'hFF);
    add(8'hF0); add(8'h02); add(8'h11); add(8'h22); add(8'h33);
    add(8'hF4); add(8'h01); add(8'h00); add(8'h44); add(8'h55);
    add(8'hF8); add(8'h00); add(8'h00); add(8'h00); add(8'h66);
    add(8'hFC); add(8'h00); add(8'h00); add(8'h00); add(8'h00); add(8'h77);
    add(8'h1D); add(8'h01);
    add(8'hFE); add(8'h03); add(8'h00);
    add(8'h03); add(8'h05); add(8'h00); add(8'h00); add(8'h00);
    add(8'h04); add(8'h00); add(8'h80, 1);
    // overlong preamble, then swallowed bytes
    repeat (10) add(8'h80);
    add(8'h12); add(8'h34, 1);
    // zero offset and offset beyond output
    add(8'h00); add(8'h01); add(8'h00); add(8'hAB, 1);
    add(8'h00); add(8'h00); add(8'hAA); add(8'h02); add(8'h02); add(8'h00); add(8'h00, 1);
    // truncation in each phase
    add(8'h80, 1);
    add(8'h00); add(8'h08, 1);
    add(8'h00); add(8'hF4); add(8'h00, 1);
    add(8'h00); add(8'h08); add(8'h11, 1);
    add(8'h00); add(8'h00); add(8'h55); add(8'h02); add(8'h01, 1);
    // empty stream
    add(8'h00, 1);
  endfunction

  function automatic int random_stream();
    comp_byte_t  s[$];
    comp_byte_t  c;
    int          produced;
    int          n_pre;
    int          len;
    int          off;
    int          pick;
    int          broken;
    c.last = 1'b0;
    produced = 0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        c.data = 8'($urandom_range(0, 255));
        s = {s, c};
      end
    end else begin
      n_pre = $urandom_range(1, 3);
      for (int i = 1; i < n_pre; i++) begin
        c.data = 8'($urandom_range(128, 255));
        s = {s, c};
      end
      c.data = 8'($urandom_range(0, 127));
      s = {s, c};
      repeat ($urandom_range(1, 6)) begin
        pick = (produced == 0) ? 0 : $urandom_range(0, 4);
        if (pick <= 1) begin
          if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(0, 15) + 1;
            c.data = 8'hF0;
            s = {s, c};
            c.data = 8'(len - 1);
            s = {s, c};
          end else begin
            len = $urandom_range(1, 8);
            c.data = 8'((len - 1) << 2);
            s = {s, c};
          end
          repeat (len) begin
            c.data = 8'($urandom_range(0, 255));
            s = {s, c};
          end
        end else begin
          off = $urandom_range(1, produced < 2047 ? produced : 2047);
          if (pick == 2) begin
            len = $urandom_range(4, 11);
            c.data = 8'(((off >> 8) << 5) | ((len - 4) << 2) | TAG_COPY1);
            s = {s, c};
            c.data = off[7:0];
            s = {s, c};
          end else begin
            len = $urandom_range(1, 64);
            c.data = 8'(((len - 1) << 2) | (pick == 3 ? TAG_COPY2 : TAG_COPY4));
            s = {s, c};
            c.data = off[7:0];
            s = {s, c};
            c.data = off[15:8];
            s = {s, c};
            if (pick == 4) begin
              c.data = 8'h00;
              s = {s, c};
              s = {s, c};
            end
          end
        end
        produced += len;
      end
      broken = $urandom_range(0, 7);
      if (broken == 0) begin
        while (s.size() > 1 && $urandom_range(0, 1)) void'(s.pop_back());
      end else if (broken == 1) begin
        off = $urandom_range(0, 1) ? 0 : produced + 1;
        c.data = 8'h02;
        s = {s, c};
        c.data = off[7:0];
        s = {s, c};
        c.data = off[15:8];
        s = {s, c};
        c.data = 8'($urandom_range(0, 255));
        s = {s, c};
      end
    end
    s[s.size()-1].last = 1'b1;
    comp_q = {comp_q, s};
    return s.size();
  endfunction

  task automatic send_byte(comp_byte_t c, int count);
    int gap;
    gap = draw_gap(count);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c.data;
    in_tlast  <= c.last;
    do @(posedge clk); while (!in_tready);
    sb.note_input(c.data, c.last);
    @(negedge clk);
  endtask

  initial begin
    int n_random;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tlast   = 1'b0;
    sb.errors  = 0;
    sb.restart();
    directed_streams();
    n_random = comp_q.size();
    while (n_random < 280) n_random += random_stream();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    foreach (comp_q[i]) send_byte(comp_q[i], i);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** snappy_raw_decompressor: PASSED **");
    end else begin
      $display("** snappy_raw_decompressor: FAILED **");
    end
    $finish;
  end

  initial begin
    int gap;
    int count;
    out_tready = 1'b0;
    count = 0;
    repeat (7) @(negedge clk);
    forever begin
      gap = draw_gap(-1 - count);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      count++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
      $display("** snappy_raw_decompressor: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
